// File: src/dvrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance-vector route table package
// Shared sizes, codes and the route entry type.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam logic [7:0] HOP_LIMIT   = 8'd100;
  localparam logic [7:0] DIRECT_HOPS = 8'd1;
  localparam logic [7:0] HOPS_MAX    = 8'hFF;

  typedef enum logic [1:0] {
    OP_ADVERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_LINK   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_IMPROVED = 3'd1,
    STAT_IGNORED  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_FOUND    = 3'd4,
    STAT_NOROUTE  = 3'd5
  } status_e;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] via;
    logic [7:0]  hops;
  } dvrt_entry_t;

endpackage

// File: src/distance_vector_route_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance-vector route table
// Route store with advert, lookup and link handling over a scanned memory.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the input channel (in_valid_i / in_stall_o) carrying an
// op code, a destination, a via address and a hop count. Every item yields
// exactly one result beat on the output channel (out_valid_o / out_stall_i).
// The router's own address is written through cfg_we_i / cfg_wdata_i; the
// user must do so only while the block is idle, which the block itself does
// not enforce. Each item sweeps all TABLE_DEPTH entries of the route memory,
// one read per cycle through its single read port, then passes through the
// last-compare step and the write-back step. The sequencer returns to idle
// after the write-back and takes new items only in idle, so it cannot take
// the next item before it is through with the last one.
// The result sits in an output register, so the next item is accepted while
// a result still waits; if the receiver stalls long enough that the next
// result is ready too, the block holds in its write-back step until the
// output register frees up. Reset clears the valid bits (empty table) and
// the own address; the memory contents need no clearing.
// ----------------------------------------------------------------------------
module distance_vector_route_table (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] dest_addr_i,
  input  logic [31:0] via_addr_i,
  input  logic [7:0]  hop_count_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        advertise_o,
  output logic [31:0] out_dest_o,
  output logic [31:0] out_via_o,
  output logic [7:0]  out_hops_o
);

  localparam int IW = dvrt_pkg::IDX_W;

  // Sequencer codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [31:0] own_addr_q;

  // Item registers, captured on the input beat.
  logic [1:0]  item_op_q;
  logic [31:0] item_dest_q;
  logic [31:0] item_via_q;
  logic [7:0]  item_hops_q;

  // Scan address and read pipeline.
  logic [IW-1:0] addr_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;
  logic          rd_ent_v_q;
  dvrt_pkg::dvrt_entry_t rd_data;

  logic [dvrt_pkg::TABLE_DEPTH-1:0] valid_q;

  // Scan results.
  logic          match_found_q;
  logic [IW-1:0] match_idx_q;
  logic [7:0]    match_hops_q;
  logic          free_found_q;
  logic [IW-1:0] free_idx_q;
  logic          best_found_q;
  logic [7:0]    best_hops_q;
  logic [31:0]   best_via_q;

  // Output register.
  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic        out_adv_q;
  logic [31:0] out_dest_q;
  logic [31:0] out_via_q;
  logic [7:0]  out_hops_q;

  logic        in_accept;
  logic        out_free;
  logic        finish;
  logic        last_addr;
  logic [31:0] key_via;
  logic        hit_dest;
  logic        hit_pair;

  // Write-back and result of the finishing step.
  logic                  wr_en;
  logic                  wr_set_valid;
  logic [IW-1:0]         wr_idx;
  dvrt_pkg::dvrt_entry_t wr_entry;
  logic [2:0]            res_status;
  logic                  res_adv;
  logic [31:0]           res_dest;
  logic [31:0]           res_via;
  logic [7:0]            res_hops;
  logic [7:0]            adv_hops;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == ST_DONE) && out_free;
  assign last_addr  = (addr_q == IW'(dvrt_pkg::TABLE_DEPTH - 1));

  // Adverts match on the advertising router; links on this router.
  assign key_via  = (item_op_q == dvrt_pkg::OP_ADVERT) ? item_via_q : own_addr_q;
  assign hit_dest = rd_vld_q && rd_ent_v_q && (rd_data.dest == item_dest_q);
  assign hit_pair = hit_dest && (rd_data.via == key_via);

  dvrt_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (wr_entry),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_SCAN;
      ST_SCAN: if (last_addr) state_d = ST_LAST;
      ST_LAST: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign adv_hops = (item_hops_q == dvrt_pkg::HOPS_MAX) ? dvrt_pkg::HOPS_MAX
                                                        : item_hops_q + 8'd1;

  // Decide the outcome from the finished scan.
  always_comb begin
    wr_en         = 1'b0;
    wr_set_valid  = 1'b0;
    wr_idx        = free_idx_q;
    wr_entry.dest = item_dest_q;
    wr_entry.via  = key_via;
    wr_entry.hops = item_hops_q;
    res_status    = dvrt_pkg::STAT_IGNORED;
    res_adv       = 1'b0;
    res_dest      = '0;
    res_via       = '0;
    res_hops      = '0;
    case (item_op_q)
      dvrt_pkg::OP_ADVERT: begin
        // Loop adverts and adverts for this router are dropped.
        if (item_via_q != item_dest_q && item_dest_q != own_addr_q) begin
          if (!match_found_q) begin
            if (!free_found_q) begin
              res_status = dvrt_pkg::STAT_FULL;
            end else begin
              wr_en        = 1'b1;
              wr_set_valid = 1'b1;
              res_status   = dvrt_pkg::STAT_INSERTED;
              res_adv      = 1'b1;
              res_dest     = item_dest_q;
              res_via      = own_addr_q;
              res_hops     = adv_hops;
            end
          end else if (match_hops_q > item_hops_q) begin
            wr_en      = 1'b1;
            wr_idx     = match_idx_q;
            res_status = dvrt_pkg::STAT_IMPROVED;
          end
        end
      end
      dvrt_pkg::OP_LOOKUP: begin
        if (best_found_q) begin
          res_status = dvrt_pkg::STAT_FOUND;
          res_dest   = item_dest_q;
          res_via    = best_via_q;
          res_hops   = best_hops_q;
        end else begin
          res_status = dvrt_pkg::STAT_NOROUTE;
        end
      end
      dvrt_pkg::OP_LINK: begin
        wr_entry.hops = dvrt_pkg::DIRECT_HOPS;
        if (!match_found_q) begin
          if (!free_found_q) begin
            res_status = dvrt_pkg::STAT_FULL;
          end else begin
            wr_en        = 1'b1;
            wr_set_valid = 1'b1;
            res_status   = dvrt_pkg::STAT_INSERTED;
          end
        end
      end
      default: res_status = dvrt_pkg::STAT_IGNORED;
    endcase
    if (!finish) begin
      wr_en        = 1'b0;
      wr_set_valid = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      own_addr_q  <= '0;
      valid_q     <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        own_addr_q <= cfg_wdata_i;
      end
      if (wr_set_valid) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (in_accept || state_q == ST_SCAN) begin
        addr_q <= (in_accept || last_addr) ? '0 : addr_q + IW'(1);
      end
      rd_vld_q <= (state_q == ST_SCAN);
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and scan bookkeeping.
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= addr_q;
    rd_ent_v_q <= valid_q[addr_q];
    if (in_accept) begin
      item_op_q     <= op_i;
      item_dest_q   <= dest_addr_i;
      item_via_q    <= via_addr_i;
      item_hops_q   <= hop_count_i;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      best_found_q  <= 1'b0;
      best_hops_q   <= dvrt_pkg::HOP_LIMIT;
    end else if (rd_vld_q) begin
      // Only the first pair match and the first free entry are kept.
      if (hit_pair && !match_found_q) begin
        match_found_q <= 1'b1;
        match_idx_q   <= rd_idx_q;
        match_hops_q  <= rd_data.hops;
      end
      if (!rd_ent_v_q && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= rd_idx_q;
      end
      // Strictly lower count wins, so ties keep the lower entry.
      if (hit_dest && rd_data.hops < best_hops_q) begin
        best_found_q <= 1'b1;
        best_hops_q  <= rd_data.hops;
        best_via_q   <= rd_data.via;
      end
    end
    if (finish) begin
      out_status_q <= res_status;
      out_adv_q    <= res_adv;
      out_dest_q   <= res_dest;
      out_via_q    <= res_via;
      out_hops_q   <= res_hops;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign advertise_o = out_adv_q;
  assign out_dest_o  = out_dest_q;
  assign out_via_o   = out_via_q;
  assign out_hops_o  = out_hops_q;

`ifndef NO_ASSERTIONS
  // The table is only written in the write-back step.
  a_write_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == ST_DONE)
    else $error("route memory written outside write-back");

  // The last compare always has read data in flight.
  a_last_has_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LAST |-> rd_vld_q)
    else $error("read pipeline empty at last compare");

  // Only fresh advert insertions advertise.
  a_adv_inserted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && advertise_o |-> status_o == dvrt_pkg::STAT_INSERTED)
    else $error("advert without insertion");

  // Found routes are below the hop limit.
  a_found_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dvrt_pkg::STAT_FOUND |-> out_hops_o < dvrt_pkg::HOP_LIMIT)
    else $error("found route at or above hop limit");
`endif

endmodule

// File: src/dvrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route entry memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dvrt_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [dvrt_pkg::IDX_W-1:0]    waddr_i,
  input  dvrt_pkg::dvrt_entry_t         wdata_i,
  input  logic [dvrt_pkg::IDX_W-1:0]    raddr_i,
  output dvrt_pkg::dvrt_entry_t         rdata_o
);

  dvrt_pkg::dvrt_entry_t mem [dvrt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: verif/distance_vector_route_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance-vector route table testbench
// Drives adverts, lookups, links and unused op codes into the route table
// under several own addresses. A behavioral copy of the table predicts every
// result beat, and the monitor compares each beat field by field. The sender
// idles at random and the receiver stalls at random.
// ----------------------------------------------------------------------------
module distance_vector_route_table_test;

  import dvrt_pkg::*;

  // The op code space has one value that the block does not use.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES = 7;
  localparam int ITEM_CYCLES  = TABLE_DEPTH + 2;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 500;
  localparam int POOL_SIZE    = 6;

  // One expected result beat.
  typedef struct {
    status_e     status;
    logic        advertise;
    logic [31:0] dest;
    logic [31:0] via;
    logic [7:0]  hops;
  } route_result_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic [1:0]  in_op     = '0;
  logic [31:0] in_dest   = '0;
  logic [31:0] in_via    = '0;
  logic [7:0]  in_hops   = '0;
  logic        out_stall = 1'b0;
  int          hold_requests = 0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic        advertise_o;
  logic [31:0] out_dest_o;
  logic [31:0] out_via_o;
  logic [7:0]  out_hops_o;

  // Behavioral copy of the route table and the own address register.
  logic        tbl_valid [TABLE_DEPTH];
  logic [31:0] tbl_dest  [TABLE_DEPTH];
  logic [31:0] tbl_via   [TABLE_DEPTH];
  logic [7:0]  tbl_hops  [TABLE_DEPTH];
  logic [31:0] own_addr_model = '0;

  route_result_t expected_routes[$];

  // Address pools keep the random traffic on a small set of routes so that
  // pairs repeat, improvements happen and lookups hit.
  logic [31:0] dest_pool [POOL_SIZE];
  logic [31:0] via_pool  [POOL_SIZE];

  int failures        = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int stall_cycles    = 0;
  int own_settings    = 0;
  int burst_left      = 1;
  int cycle_count     = 0;
  int status_seen [8];

  distance_vector_route_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .op_i        (in_op),
    .dest_addr_i (in_dest),
    .via_addr_i  (in_via),
    .hop_count_i (in_hops),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .status_o    (status_o),
    .advertise_o (advertise_o),
    .out_dest_o  (out_dest_o),
    .out_via_o   (out_via_o),
    .out_hops_o  (out_hops_o)
  );

  always #10 clk_i = ~clk_i;

  // Index of the stored route for a (destination, next hop) pair, or -1.
  function automatic int find_route(input logic [31:0] dest, input logic [31:0] via);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_dest[i] == dest && tbl_via[i] == via) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Puts a route into the lowest free entry. Since entries are never freed,
  // a full table simply refuses the route.
  function automatic status_e store_route(input logic [31:0] dest, input logic [31:0] via,
                                          input logic [7:0] hops);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_dest[i]  = dest;
        tbl_via[i]   = via;
        tbl_hops[i]  = hops;
        return STAT_INSERTED;
      end
    end
    return STAT_FULL;
  endfunction

  // Applies one input beat to the table copy and returns its result beat.
  function automatic route_result_t predict_route(input logic [1:0] op,
                                                  input logic [31:0] dest,
                                                  input logic [31:0] via,
                                                  input logic [7:0] hops);
    route_result_t r;
    int            slot;
    int            best;
    logic [7:0]    best_hops;
    r = '{STAT_IGNORED, 1'b0, 32'd0, 32'd0, 8'd0};
    case (op)
      OP_ADVERT: begin
        // Loop adverts and adverts for this router itself are dropped.
        if (via != dest && dest != own_addr_model) begin
          slot = find_route(dest, via);
          if (slot < 0) begin
            r.status = store_route(dest, via, hops);
            if (r.status == STAT_INSERTED) begin
              r.advertise = 1'b1;
              r.dest      = dest;
              r.via       = own_addr_model;
              r.hops      = (hops == HOPS_MAX) ? HOPS_MAX : hops + 8'd1;
            end
          end else if (tbl_hops[slot] > hops) begin
            // An improvement only lowers the stored count, silently.
            tbl_hops[slot] = hops;
            r.status       = STAT_IMPROVED;
          end
        end
      end
      OP_LOOKUP: begin
        // Strictly lower wins, so the lowest entry keeps a tie, and nothing
        // at or above the hop limit ever qualifies.
        best      = -1;
        best_hops = HOP_LIMIT;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i] && tbl_dest[i] == dest && tbl_hops[i] < best_hops) begin
            best      = i;
            best_hops = tbl_hops[i];
          end
        end
        if (best >= 0) begin
          r.status = STAT_FOUND;
          r.dest   = tbl_dest[best];
          r.via    = tbl_via[best];
          r.hops   = tbl_hops[best];
        end else begin
          r.status = STAT_NOROUTE;
        end
      end
      OP_LINK: begin
        if (find_route(dest, own_addr_model) < 0) begin
          r.status = store_route(dest, own_addr_model, DIRECT_HOPS);
        end
      end
      default: begin
        r.status = STAT_IGNORED;
      end
    endcase
    return r;
  endfunction

  // Hop counts lean toward small values so that improvements are common, with
  // a band around the lookup limit and the full range for the rest.
  function automatic logic [7:0] random_hops();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      return 8'($urandom_range(0, 15));
    end else if (pick < 8) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(95, 105));
  endfunction

  // Offers one beat, waits for it to be taken, records its prediction and
  // then paces the sender in bursts separated by idle gaps.
  task automatic send_item(input logic [1:0] op, input logic [31:0] dest,
                           input logic [31:0] via, input logic [7:0] hops);
    in_valid <= 1'b1;
    in_op    <= op;
    in_dest  <= dest;
    in_via   <= via;
    in_hops  <= hops;
    @(posedge clk_i);
    while (in_stall_o) begin
      stall_cycles++;
      @(posedge clk_i);
    end
    expected_routes.push_back(predict_route(op, dest, via, hops));
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  // Waits until every outstanding result beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the own address while the block has nothing in flight.
  task automatic write_own_addr(input logic [31:0] addr);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk_i);
    cfg_we         <= 1'b0;
    own_addr_model  = addr;
    dest_pool[0]    = addr;
    via_pool[4]     = addr;
    own_settings++;
  endtask

  // An empty table finds nothing; the unused op and a self advert are dropped.
  task automatic test_empty_table();
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_ADVERT, 32'h0000_0000, 32'hFFFF_FFFF, 8'h03);
  endtask

  // Advert handling: loop, self, saturation, equal, improvement, higher count.
  task automatic test_advert_rules();
    send_item(OP_ADVERT, 32'h1234_5678, 32'h1234_5678, 8'h02);
    send_item(OP_ADVERT, own_addr_model, 32'h0000_0001, 8'h02);
    send_item(OP_ADVERT, 32'h0000_0000, 32'h0000_0001, 8'hFF);
    send_item(OP_ADVERT, 32'h0000_0000, 32'h0000_0001, 8'hFF);
    send_item(OP_ADVERT, 32'h0000_0000, 32'h0000_0001, 8'h00);
    send_item(OP_ADVERT, 32'h0000_0000, 32'h0000_0001, 8'h05);
    send_item(OP_ADVERT, 32'h0000_0000, 32'h0000_0002, 8'h00);
    send_item(OP_ADVERT, 32'hAAAA_AAAA, 32'h5555_5555, 8'hFE);
  endtask

  // Lookup ties, the hop limit and a later better route.
  task automatic test_lookup_rules();
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'h00);
    send_item(OP_ADVERT, 32'hFFFF_FFFE, 32'h7FFF_FFFF, HOP_LIMIT);
    send_item(OP_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 8'h00);
    send_item(OP_ADVERT, 32'hFFFF_FFFE, 32'h0000_0003, HOP_LIMIT - 8'd1);
    send_item(OP_ADVERT, 32'hFFFF_FFFE, 32'h8000_0000, HOP_LIMIT - 8'd1);
    send_item(OP_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 8'h00);
    send_item(OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 8'h00);
  endtask

  // Direct links: new, already present, to this router, then adverts that
  // land on the pair a link created.
  task automatic test_link_rules();
    send_item(OP_LINK, 32'h0BAD_F00D, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_LINK, 32'h0BAD_F00D, 32'h0000_0000, 8'h00);
    send_item(OP_LINK, own_addr_model, 32'h0000_0000, 8'h00);
    send_item(OP_LOOKUP, own_addr_model, 32'h0000_0000, 8'h00);
    send_item(OP_ADVERT, 32'h0BAD_F00D, own_addr_model, 8'h01);
    send_item(OP_ADVERT, 32'h0BAD_F00D, own_addr_model, 8'h00);
  endtask

  // Mostly well-formed traffic over the address pools, with some noise.
  task automatic test_random_routes(input int count);
    logic [1:0]  op;
    logic [31:0] dest;
    logic [31:0] via;
    logic [7:0]  hops;
    int          pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      dest = dest_pool[$urandom_range(0, POOL_SIZE - 1)];
      via  = via_pool[$urandom_range(0, POOL_SIZE - 1)];
      hops = random_hops();
      if (pick < 42) begin
        op = OP_ADVERT;
      end else if (pick < 72) begin
        op = OP_LOOKUP;
        if ($urandom_range(0, 9) == 0) begin
          dest = $urandom;
        end
      end else if (pick < 88) begin
        op = OP_LINK;
      end else if (pick < 94) begin
        op   = 2'($urandom_range(0, 3));
        dest = $urandom;
        via  = $urandom;
        hops = 8'($urandom_range(0, 255));
      end else begin
        op = OP_UNUSED;
      end
      send_item(op, dest, via, hops);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the output register and then the input side back up.
  task automatic test_output_backpressure();
    hold_requests++;
    burst_left = 40;
    for (int i = 0; i < 12; i++) begin
      send_item(i[0] ? OP_LOOKUP : OP_ADVERT, dest_pool[i % POOL_SIZE],
                via_pool[(i + 1) % POOL_SIZE], random_hops());
    end
  endtask

  // Fills every free entry, then checks that new routes are refused while
  // known routes still resolve.
  task automatic test_table_full();
    int stored;
    stored = 0;
    while (stored < TABLE_DEPTH) begin
      send_item(OP_ADVERT, $urandom, $urandom, random_hops());
      stored = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (tbl_valid[i]) begin
          stored++;
        end
      end
    end
    send_item(OP_ADVERT, 32'hDEAD_0001, 32'hDEAD_0002, 8'h00);
    send_item(OP_ADVERT, 32'h0000_0000, 32'h0000_0009, 8'h00);
    send_item(OP_LINK, 32'hDEAD_0003, 32'h0000_0000, 8'h00);
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'h00);
  endtask

  // Result monitor: every accepted beat is matched against the oldest
  // prediction, one field at a time.
  always @(posedge clk_i) begin
    route_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_routes.size() == 0) begin
        $error("result beat with nothing expected: status %0d dest %h", status_o, out_dest_o);
        failures++;
      end else begin
        want = expected_routes.pop_front();
        results_checked++;
        status_seen[status_o]++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          failures++;
        end
        if (advertise_o !== want.advertise) begin
          $error("advertise: expected %0d, actual %0d", want.advertise, advertise_o);
          failures++;
        end
        if (out_dest_o !== want.dest) begin
          $error("out_dest: expected %h, actual %h", want.dest, out_dest_o);
          failures++;
        end
        if (out_via_o !== want.via) begin
          $error("out_via: expected %h, actual %h", want.via, out_via_o);
          failures++;
        end
        if (out_hops_o !== want.hops) begin
          $error("out_hops: expected %0d, actual %0d", want.hops, out_hops_o);
          failures++;
        end
      end
    end
  end

  // Receiver stall pattern. It switches between free flow, light and heavy
  // random stalling and short solid stalls, and runs the long hold-off when
  // a test asks for it.
  always @(posedge clk_i) begin
    int hold_left;
    int hold_served;
    int mode_left;
    int stall_mode;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = (stall_mode == 3) ? $urandom_range(1, 20) : $urandom_range(5, 80);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  // Run limit, far above the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, expected_routes.size());
      $display("distance_vector_route_table test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_dest[i]  = '0;
      tbl_via[i]   = '0;
      tbl_hops[i]  = '0;
    end
    for (int i = 0; i < 8; i++) begin
      status_seen[i] = 0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      dest_pool[i] = $urandom;
      via_pool[i]  = $urandom;
    end
    // One next hop doubles as a destination so that loop adverts show up.
    via_pool[POOL_SIZE - 1] = dest_pool[1];

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The own address still holds its reset value here.
    test_empty_table();

    write_own_addr(32'hFFFF_FFFF);
    test_advert_rules();
    test_lookup_rules();
    test_link_rules();

    write_own_addr($urandom);
    test_random_routes(200);
    write_own_addr(32'h0000_0000);
    test_random_routes(200);
    write_own_addr($urandom);
    test_random_routes(200);

    test_output_backpressure();
    drain_results();

    test_table_full();
    write_own_addr($urandom);
    test_random_routes(400);

    drain_results();
    repeat (2 * ITEM_CYCLES) @(posedge clk_i);

    $display("Sent %0d beats (adverts, lookups, links, unused op) under %0d own addresses,",
             items_sent, own_settings);
    $display("with %0d input stall cycles; checked %0d results: %0d inserted, %0d improved,",
             stall_cycles, results_checked, status_seen[STAT_INSERTED],
             status_seen[STAT_IMPROVED]);
    $display("%0d ignored, %0d full, %0d found, %0d no route.",
             status_seen[STAT_IGNORED], status_seen[STAT_FULL], status_seen[STAT_FOUND],
             status_seen[STAT_NOROUTE]);
    if (failures == 0 && expected_routes.size() == 0) begin
      $display("distance_vector_route_table test passed");
    end else begin
      $display("distance_vector_route_table test failed");
    end
    $finish;
  end

endmodule
